### rtl/core/forward_kinematics_chain_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the forward kinematics RTL.
// ----------------------------------------------------------------------------
`ifndef FORWARD_KINEMATICS_CHAIN_ASSERT_SVH
`define FORWARD_KINEMATICS_CHAIN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FKC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fkc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fkc assertion failed");

`endif

### rtl/core/fkc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fkc_pkg
// Types, constants and fixed-point helpers of the forward kinematics chain.
// ============================================================================
package fkc_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 66;
    localparam int TRN_W  = 48;
    localparam int CRD_W  = 34;
    localparam int CORDIC_STEPS = 23;

    // Angles in Q16.16 degrees, widened to the CORDIC word.
    localparam logic signed [CRD_W-1:0] C_DEG360   = 34'sd23592960;
    localparam logic signed [CRD_W-1:0] C_DEG180   = 34'sd11796480;
    localparam logic signed [CRD_W-1:0] C_DEG90    = 34'sd5898240;
    // 128 turns lift any 32-bit angle to a positive value.
    localparam logic signed [CRD_W-1:0] C_ANG_BIAS = 34'sd3019898880;
    localparam logic signed [CRD_W-1:0] C_CORDIC_K = 34'sd652032874;
    localparam logic signed [CRD_W-1:0] C_ONE_CRD  = 34'sd1073741824;

    localparam logic signed [DATA_W-1:0] C_ONE_Q30 = 32'sd1073741824;
    localparam logic signed [DATA_W-1:0] C_ZERO    = 32'sd0;

    localparam logic signed [ACC_W-1:0] C_HALF_Q30 = 66'sd536870912;
    localparam logic signed [ACC_W-1:0] C_MAX32    = 66'sd2147483647;
    localparam logic signed [ACC_W-1:0] C_MIN32    = -66'sd2147483648;
    localparam logic signed [ACC_W-1:0] C_MAX48    = 66'sd140737488355327;
    localparam logic signed [ACC_W-1:0] C_MIN48    = -66'sd140737488355328;

    typedef struct packed {
        logic load;   // accumulator takes the initial value
        logic mul;    // product register takes a * b
        logic add;    // accumulator adds the product
        logic rnd;    // product is rounded at bit 30 before the add
    } t_mac_ctrl;

    // Arctangent of 2^-i in Q16.16 degrees.
    function automatic logic signed [CRD_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [CRD_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sd2949120;
            5'd1:  v = 34'sd1740967;
            5'd2:  v = 34'sd919879;
            5'd3:  v = 34'sd466945;
            5'd4:  v = 34'sd234379;
            5'd5:  v = 34'sd117304;
            5'd6:  v = 34'sd58666;
            5'd7:  v = 34'sd29335;
            5'd8:  v = 34'sd14668;
            5'd9:  v = 34'sd7334;
            5'd10: v = 34'sd3667;
            5'd11: v = 34'sd1833;
            5'd12: v = 34'sd917;
            5'd13: v = 34'sd458;
            5'd14: v = 34'sd229;
            5'd15: v = 34'sd115;
            5'd16: v = 34'sd57;
            5'd17: v = 34'sd29;
            5'd18: v = 34'sd14;
            5'd19: v = 34'sd7;
            5'd20: v = 34'sd4;
            5'd21: v = 34'sd2;
            5'd22: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Round half up at bit 30 and saturate to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat_q30(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        logic signed [DATA_W-1:0] r;
        s = (a + C_HALF_Q30) >>> 30;
        if (s > C_MAX32) begin
            r = 32'sh7FFFFFFF;
        end else if (s < C_MIN32) begin
            r = 32'sh80000000;
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [TRN_W-1:0] sat48(input logic signed [ACC_W-1:0] a);
        logic signed [TRN_W-1:0] r;
        if (a > C_MAX48) begin
            r = C_MAX48[TRN_W-1:0];
        end else if (a < C_MIN48) begin
            r = C_MIN48[TRN_W-1:0];
        end else begin
            r = a[TRN_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32_48(input logic signed [TRN_W-1:0] t);
        logic signed [DATA_W-1:0] r;
        if (t > 48'sh00007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (t < -48'sh000080000000) begin
            r = 32'sh80000000;
        end else begin
            r = t[DATA_W-1:0];
        end
        return r;
    endfunction

    // Row-major index of a 3x3 entry.
    function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
        return ({2'b00, row} << 1) + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

### rtl/core/fkc_if.sv
`timescale 1ns / 1ps
// ============================================================================
// fkc_if
// Valid/ready channels of the forward kinematics chain: joints in, positions out.
// ============================================================================
interface fkc_joint_if;
    logic               valid;
    logic               ready;
    logic               chain_start;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic signed [31:0] angle_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;

    modport source (
        output valid, chain_start, disp_x, disp_y, disp_z, angle_z, angle_x, angle_y,
        input  ready
    );
    modport sink (
        input  valid, chain_start, disp_x, disp_y, disp_z, angle_z, angle_x, angle_y,
        output ready
    );
endinterface

interface fkc_pos_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

### rtl/core/fkc_cordic.sv
`timescale 1ns / 1ps
`include "forward_kinematics_chain_assert.svh"
// ============================================================================
// fkc_cordic
// Iterative sine/cosine of an angle in Q16.16 degrees, Q2.30 results.
// ============================================================================
module fkc_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_angle,
    output logic               o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    import fkc_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_MOD  = 5'b00010,
        C_FOLD = 5'b00100,
        C_ITER = 5'b01000,
        C_DONE = 5'b10000
    } t_cstate;

    t_cstate                 r_state, n_state;
    logic signed [CRD_W-1:0] r_z, r_x, r_y;
    logic [4:0]              r_cnt;
    logic                    r_neg;

    logic signed [CRD_W-1:0] w_mod_sub, w_wrap, w_fold, w_dx, w_dy, w_at;
    logic                    w_neg;

    function automatic logic signed [31:0] clamp_q30(input logic signed [CRD_W-1:0] v);
        logic signed [31:0] r;
        if (v > C_ONE_CRD) begin
            r = C_ONE_Q30;
        end else if (v < -C_ONE_CRD) begin
            r = -C_ONE_Q30;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Restoring reduction: subtract 360 degrees times 2^cnt while it fits.
    assign w_mod_sub = C_DEG360 <<< r_cnt[2:0];

    always_comb begin
        w_wrap = (r_z > C_DEG180) ? (r_z - C_DEG360) : r_z;
        w_fold = w_wrap;
        w_neg  = 1'b0;
        if (w_wrap > C_DEG90) begin
            w_fold = w_wrap - C_DEG180;
            w_neg  = 1'b1;
        end else if (w_wrap < -C_DEG90) begin
            w_fold = w_wrap + C_DEG180;
            w_neg  = 1'b1;
        end
    end

    assign w_dx = r_y >>> r_cnt;
    assign w_dy = r_x >>> r_cnt;
    assign w_at = atan_deg(r_cnt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_MOD;
            C_MOD:  if (r_cnt == 5'd0) n_state = C_FOLD;
            C_FOLD: n_state = C_ITER;
            C_ITER: if (r_cnt == 5'(CORDIC_STEPS - 1)) n_state = C_DONE;
            C_DONE: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_z   <= {{(CRD_W - 32){i_angle[31]}}, i_angle} + C_ANG_BIAS;
                r_cnt <= 5'd7;
            end
            C_MOD: begin
                if (r_z >= w_mod_sub) begin
                    r_z <= r_z - w_mod_sub;
                end
                r_cnt <= r_cnt - 5'd1;
            end
            C_FOLD: begin
                r_z   <= w_fold;
                r_neg <= w_neg;
                r_x   <= C_CORDIC_K;
                r_y   <= '0;
                r_cnt <= 5'd0;
            end
            C_ITER: begin
                if (!r_z[CRD_W-1]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == C_DONE);
    assign o_cos  = clamp_q30(r_neg ? -r_x : r_x);
    assign o_sin  = clamp_q30(r_neg ? -r_y : r_y);

    `FKC_ASSERT_IMPL(a_iter_count, i_clk, i_rst_n, r_state == C_ITER, r_cnt <= 5'(CORDIC_STEPS - 1))
    `FKC_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

endmodule

### rtl/core/fkc_mac.sv
`timescale 1ns / 1ps
// ============================================================================
// fkc_mac
// Shared 32x32 signed multiplier with a registered product and a wide accumulator.
// ============================================================================
module fkc_mac (
    input  logic                              i_clk,
    input  fkc_pkg::t_mac_ctrl                i_ctrl,
    input  logic signed [fkc_pkg::DATA_W-1:0] i_a,
    input  logic signed [fkc_pkg::DATA_W-1:0] i_b,
    input  logic signed [fkc_pkg::ACC_W-1:0]  i_init,
    output logic signed [fkc_pkg::ACC_W-1:0]  o_acc
);
    import fkc_pkg::*;

    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    w_prod_ext, w_prod_rnd;

    assign w_prod_ext = {{(ACC_W - 2*DATA_W){r_prod[2*DATA_W-1]}}, r_prod};
    // Round half up at bit 30, floor shift.
    assign w_prod_rnd = (w_prod_ext + C_HALF_Q30) >>> 30;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctrl.load) begin
            r_acc <= i_init;
        end else if (i_ctrl.add) begin
            r_acc <= r_acc + (i_ctrl.rnd ? w_prod_rnd : w_prod_ext);
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/core/forward_kinematics_chain.sv
`timescale 1ns / 1ps
`include "forward_kinematics_chain_assert.svh"
// ============================================================================
// forward_kinematics_chain
// Folds one skeleton joint per word into an accumulated transform and
// returns the joint's world position.
// ============================================================================
// The block takes one joint word at a time and is busy until its position
// word has been taken. After a joint word is accepted, three sine/cosine
// evaluations run on one iterative CORDIC (each a start state, a modulo
// reduction, a fold, 23 rotation steps and a done state), then 90
// multiply-accumulate operations on a single shared 32x32 multiplier, each
// a multiply and an accumulate state (three 3x3 matrix products and the
// 3x3 translation update), with a load and a write state for each of the
// 30 results, one build and three transfer states, and one output state.
// The position word waits in place until the sink takes it. A chain start
// resets the rotation to identity and the translation to zero first.
module forward_kinematics_chain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fkc_joint_if.sink     i_joint,
    fkc_pos_if.source     o_pos
);
    import fkc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ANG   = 10'b0000000010,
        S_ANGW  = 10'b0000000100,
        S_BUILD = 10'b0000001000,
        S_LD    = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_ACC   = 10'b0001000000,
        S_WR    = 10'b0010000000,
        S_XFER  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    typedef enum logic [3:0] {
        PH_MM1   = 4'b0001,
        PH_MM2   = 4'b0010,
        PH_TRANS = 4'b0100,
        PH_MM3   = 4'b1000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase;

    logic signed [DATA_W-1:0] r_disp [3];
    logic signed [DATA_W-1:0] r_ang  [3];
    logic signed [DATA_W-1:0] r_sin  [3];
    logic signed [DATA_W-1:0] r_cos  [3];
    logic signed [DATA_W-1:0] r_ma   [9];
    logic signed [DATA_W-1:0] r_mb   [9];
    logic signed [DATA_W-1:0] r_mc   [9];
    logic signed [DATA_W-1:0] r_rot  [9];
    logic signed [TRN_W-1:0]  r_trans[3];
    logic [1:0]               r_ang_sel, r_i, r_j, r_k;

    logic                     w_accept, w_cs_done, w_last_out;
    logic signed [DATA_W-1:0] w_cs_sin, w_cs_cos, w_op_a, w_op_b;
    logic signed [ACC_W-1:0]  w_init, w_acc;
    t_mac_ctrl                w_mac;

    assign w_accept      = i_joint.valid && i_joint.ready;
    assign i_joint.ready = (r_state == S_IDLE);
    assign o_pos.valid   = (r_state == S_OUT);
    assign o_pos.pos_x   = sat32_48(r_trans[0]);
    assign o_pos.pos_y   = sat32_48(r_trans[1]);
    assign o_pos.pos_z   = sat32_48(r_trans[2]);

    fkc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ANG),
        .i_angle (r_ang[r_ang_sel]),
        .o_done  (w_cs_done),
        .o_sin   (w_cs_sin),
        .o_cos   (w_cs_cos)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        if (r_phase == PH_TRANS || r_phase == PH_MM3) begin
            w_op_a = r_rot[idx3(r_i, r_k)];
        end else begin
            w_op_a = r_ma[idx3(r_i, r_k)];
        end
        if (r_phase == PH_TRANS) begin
            w_op_b = r_disp[r_k];
            w_init = {{(ACC_W - TRN_W){r_trans[r_i][TRN_W-1]}}, r_trans[r_i]};
        end else begin
            w_op_b = r_mb[idx3(r_k, r_j)];
            w_init = '0;
        end
        w_mac.load = (r_state == S_LD);
        w_mac.mul  = (r_state == S_MUL);
        w_mac.add  = (r_state == S_ACC);
        w_mac.rnd  = (r_phase == PH_TRANS);
    end

    fkc_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_mac),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .i_init (w_init),
        .o_acc  (w_acc)
    );

    assign w_last_out = (r_phase == PH_TRANS) ? (r_i == 2'd2) : (r_i == 2'd2 && r_j == 2'd2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_ANG;
            S_ANG:   n_state = S_ANGW;
            S_ANGW:  if (w_cs_done) n_state = (r_ang_sel == 2'd2) ? S_BUILD : S_ANG;
            S_BUILD: n_state = S_LD;
            S_LD:    n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_k == 2'd2) ? S_WR : S_MUL;
            S_WR: begin
                if (w_last_out && r_phase != PH_TRANS) begin
                    n_state = S_XFER;
                end else begin
                    n_state = S_LD;
                end
            end
            S_XFER:  n_state = (r_phase == PH_MM3) ? S_OUT : S_LD;
            S_OUT:   if (o_pos.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Accumulated transform: identity rotation and zero translation at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 9; n++) begin
                r_rot[n] <= (n % 4 == 0) ? C_ONE_Q30 : C_ZERO;
            end
            for (int n = 0; n < 3; n++) begin
                r_trans[n] <= '0;
            end
        end else if (w_accept && i_joint.chain_start) begin
            for (int n = 0; n < 9; n++) begin
                r_rot[n] <= (n % 4 == 0) ? C_ONE_Q30 : C_ZERO;
            end
            for (int n = 0; n < 3; n++) begin
                r_trans[n] <= '0;
            end
        end else if (r_state == S_WR && r_phase == PH_TRANS) begin
            r_trans[r_i] <= sat48(w_acc);
        end else if (r_state == S_XFER && r_phase == PH_MM3) begin
            for (int n = 0; n < 9; n++) begin
                r_rot[n] <= r_mc[n];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_disp[0] <= i_joint.disp_x;
                r_disp[1] <= i_joint.disp_y;
                r_disp[2] <= i_joint.disp_z;
                r_ang[0]  <= i_joint.angle_z;
                r_ang[1]  <= i_joint.angle_x;
                r_ang[2]  <= i_joint.angle_y;
                r_ang_sel <= 2'd0;
            end
            S_ANGW: begin
                if (w_cs_done) begin
                    r_sin[r_ang_sel] <= w_cs_sin;
                    r_cos[r_ang_sel] <= w_cs_cos;
                    r_ang_sel        <= r_ang_sel + 2'd1;
                end
            end
            S_BUILD: begin
                // Rz into the left operand, Rx into the right one.
                r_ma[0] <= r_cos[0];  r_ma[1] <= -r_sin[0]; r_ma[2] <= C_ZERO;
                r_ma[3] <= r_sin[0];  r_ma[4] <= r_cos[0];  r_ma[5] <= C_ZERO;
                r_ma[6] <= C_ZERO;    r_ma[7] <= C_ZERO;    r_ma[8] <= C_ONE_Q30;
                r_mb[0] <= C_ONE_Q30; r_mb[1] <= C_ZERO;    r_mb[2] <= C_ZERO;
                r_mb[3] <= C_ZERO;    r_mb[4] <= r_cos[1];  r_mb[5] <= -r_sin[1];
                r_mb[6] <= C_ZERO;    r_mb[7] <= r_sin[1];  r_mb[8] <= r_cos[1];
                r_phase <= PH_MM1;
                r_i     <= 2'd0;
                r_j     <= 2'd0;
                r_k     <= 2'd0;
            end
            S_ACC: begin
                r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            S_WR: begin
                if (r_phase != PH_TRANS) begin
                    r_mc[idx3(r_i, r_j)] <= sat_q30(w_acc);
                end
                if (w_last_out) begin
                    r_i <= 2'd0;
                    r_j <= 2'd0;
                    if (r_phase == PH_TRANS) begin
                        r_phase <= PH_MM3;
                    end
                end else if (r_phase == PH_TRANS || r_j == 2'd2) begin
                    r_i <= r_i + 2'd1;
                    r_j <= 2'd0;
                end else begin
                    r_j <= r_j + 2'd1;
                end
            end
            S_XFER: begin
                if (r_phase == PH_MM1) begin
                    // Rz*Rx becomes the left operand, Ry the right one.
                    for (int n = 0; n < 9; n++) begin
                        r_ma[n] <= r_mc[n];
                    end
                    r_mb[0] <= r_cos[2];  r_mb[1] <= C_ZERO;    r_mb[2] <= r_sin[2];
                    r_mb[3] <= C_ZERO;    r_mb[4] <= C_ONE_Q30; r_mb[5] <= C_ZERO;
                    r_mb[6] <= -r_sin[2]; r_mb[7] <= C_ZERO;    r_mb[8] <= r_cos[2];
                    r_phase <= PH_MM2;
                end else if (r_phase == PH_MM2) begin
                    // The joint rotation is the right operand of the final product.
                    for (int n = 0; n < 9; n++) begin
                        r_mb[n] <= r_mc[n];
                    end
                    r_phase <= PH_TRANS;
                end
            end
            default: begin
            end
        endcase
    end

    `FKC_ASSERT_IMPL(a_cs_done_waited, i_clk, i_rst_n, w_cs_done, r_state == S_ANGW)
    `FKC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !i_joint.ready)
    `FKC_ASSERT_IMPL(a_mac_index, i_clk, i_rst_n, r_state == S_MUL, (r_k != 2'd3) && (r_i != 2'd3))

endmodule
